>>> hdl/mbet_pkg.sv
// Shared types, constants and register indexes for the Mandelbrot escape-time block.
`default_nettype none
package mbet_pkg;

  localparam int unsigned IndexLimitDef    = 4096;
  localparam int unsigned IterLimitDef     = 255;
  localparam int unsigned DefaultIter      = 30;
  localparam int unsigned FracBits         = 28;
  localparam int unsigned IdxW             = 12;
  localparam int unsigned CntW             = 8;
  localparam int unsigned QW               = 32;
  localparam int unsigned StepW            = 31;
  localparam int unsigned ZW               = 33;
  localparam int unsigned SqW              = 2 * ZW;
  localparam int unsigned CfgIdxW          = 3;
  localparam logic signed [QW-1:0] QMax    = 32'sh7FFF_FFFF;
  localparam logic signed [QW-1:0] QMin    = 32'sh8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_X_FIRST  = 3'd0,
    REG_X_STEP   = 3'd1,
    REG_Y_FIRST  = 3'd2,
    REG_Y_STEP   = 3'd3,
    REG_MAX_ITER = 3'd4
  } mbet_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FORM,
    ST_MUL,
    ST_CHECK
  } mbet_state_e;

  typedef struct packed {
    logic load_c;
    logic form_c;
    logic mul;
    logic step;
    logic load_result;
  } mbet_cmd_t;

  typedef struct packed {
    logic escaped;
    logic at_limit;
  } mbet_sts_t;

endpackage
`default_nettype wire

>>> hdl/mbet_ctrl.sv
// Controller state machine sequencing point setup, iterations and result hand-off.
`default_nettype none
module mbet_ctrl (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  input  wire mbet_pkg::mbet_sts_t  sts_i,
  output mbet_pkg::mbet_cmd_t       cmd_o
);

  mbet_pkg::mbet_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mbet_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      mbet_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_c = 1'b1;
          state_d      = mbet_pkg::ST_FORM;
        end
      end
      mbet_pkg::ST_FORM: begin
        cmd_o.form_c = 1'b1;
        state_d      = mbet_pkg::ST_MUL;
      end
      mbet_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = mbet_pkg::ST_CHECK;
      end
      mbet_pkg::ST_CHECK: begin
        if (sts_i.escaped || sts_i.at_limit) begin
          if (slot_free) begin
            cmd_o.load_result = 1'b1;
            state_d           = mbet_pkg::ST_IDLE;
          end
        end else begin
          cmd_o.step = 1'b1;
          state_d    = mbet_pkg::ST_MUL;
        end
      end
      default: state_d = mbet_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_result) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  a_load_into_free_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_result |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending transaction");

  a_accept_starts_form : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == mbet_pkg::ST_FORM))
    else $error("accepted transaction did not start point setup");

  a_no_step_when_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> !(sts_i.escaped || sts_i.at_limit))
    else $error("iteration advanced after escape or limit");

  a_ready_only_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(cmd_o.mul || cmd_o.step || cmd_o.form_c))
    else $error("input ready while iterating");

endmodule
`default_nettype wire

>>> hdl/mbet_dp.sv
// Datapath: point formation, complex square-and-add iteration, escape test, result register.
`default_nettype none
module mbet_dp #(
  parameter int unsigned INDEX_LIMIT = mbet_pkg::IndexLimitDef,
  parameter int unsigned ITER_LIMIT  = mbet_pkg::IterLimitDef
) (
  input  wire                                  clk_i,
  input  wire  [mbet_pkg::IdxW-1:0]            col_i,
  input  wire  [mbet_pkg::IdxW-1:0]            row_i,
  input  wire  signed [mbet_pkg::QW-1:0]       x_first_i,
  input  wire  [mbet_pkg::StepW-1:0]           x_step_i,
  input  wire  signed [mbet_pkg::QW-1:0]       y_first_i,
  input  wire  [mbet_pkg::StepW-1:0]           y_step_i,
  input  wire  [mbet_pkg::CntW-1:0]            max_iter_i,
  input  wire  mbet_pkg::mbet_cmd_t            cmd_i,
  output mbet_pkg::mbet_sts_t                  sts_o,
  output logic [mbet_pkg::CntW-1:0]            escape_count_o
);

  localparam int unsigned CmpW  = 17;
  localparam int unsigned ProdW = mbet_pkg::IdxW + mbet_pkg::StepW;
  localparam int unsigned SumW  = ProdW + 2;
  localparam int unsigned DifW  = mbet_pkg::SqW + 1;
  localparam int unsigned NW    = mbet_pkg::ZW + 1;
  localparam logic [CmpW-1:0] IdxMax = CmpW'(INDEX_LIMIT - 1);
  localparam logic [mbet_pkg::CntW-1:0] IterMax = mbet_pkg::CntW'(ITER_LIMIT);
  localparam logic signed [DifW-1:0] FourWide =
    DifW'(1) <<< (2 * mbet_pkg::FracBits + 2);

  logic [mbet_pkg::IdxW-1:0]         col_sel, row_sel;
  logic [ProdW-1:0]                  prod_x_q, prod_y_q;
  logic signed [SumW-1:0]            sum_x, sum_y;
  logic signed [mbet_pkg::QW-1:0]    cr_q, ci_q, cr_d, ci_d;
  logic signed [mbet_pkg::ZW-1:0]    zr_q, zi_q;
  logic signed [mbet_pkg::SqW-1:0]   rr_q, ii_q, ri_q;
  logic signed [DifW-1:0]            mag, dif, dif_sh, ri_sh;
  logic signed [NW-1:0]              nr, ni;
  logic [mbet_pkg::CntW-1:0]         k_q, limit;
  logic [mbet_pkg::CntW-1:0]         count_q;

  function automatic logic signed [mbet_pkg::QW-1:0] sat_q(logic signed [SumW-1:0] v);
    logic signed [mbet_pkg::QW-1:0] r;
    if (v > SumW'(mbet_pkg::QMax)) begin
      r = mbet_pkg::QMax;
    end else if (v < SumW'(mbet_pkg::QMin)) begin
      r = mbet_pkg::QMin;
    end else begin
      r = v[mbet_pkg::QW-1:0];
    end
    return r;
  endfunction

  assign col_sel = ({(CmpW - mbet_pkg::IdxW)'(0), col_i} > IdxMax) ?
                   IdxMax[mbet_pkg::IdxW-1:0] : col_i;
  assign row_sel = ({(CmpW - mbet_pkg::IdxW)'(0), row_i} > IdxMax) ?
                   IdxMax[mbet_pkg::IdxW-1:0] : row_i;

  assign sum_x = SumW'(x_first_i) + $signed({2'b00, prod_x_q});
  assign sum_y = SumW'(y_first_i) + $signed({2'b00, prod_y_q});
  assign cr_d  = sat_q(sum_x);
  assign ci_d  = sat_q(sum_y);

  assign mag    = DifW'(rr_q) + DifW'(ii_q);
  assign dif    = DifW'(rr_q) - DifW'(ii_q);
  assign dif_sh = dif >>> mbet_pkg::FracBits;
  assign ri_sh  = DifW'(ri_q) >>> (mbet_pkg::FracBits - 1);
  assign nr     = dif_sh[NW-1:0] + NW'(cr_q);
  assign ni     = ri_sh[NW-1:0] + NW'(ci_q);

  assign limit          = (max_iter_i > IterMax) ? IterMax : max_iter_i;
  assign sts_o.escaped  = mag > FourWide;
  assign sts_o.at_limit = k_q == limit;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_c) begin
      prod_x_q <= ProdW'(col_sel) * ProdW'(x_step_i);
      prod_y_q <= ProdW'(row_sel) * ProdW'(y_step_i);
    end
    if (cmd_i.form_c) begin
      cr_q <= cr_d;
      ci_q <= ci_d;
      zr_q <= '0;
      zi_q <= '0;
      k_q  <= '0;
    end else if (cmd_i.step) begin
      zr_q <= nr[mbet_pkg::ZW-1:0];
      zi_q <= ni[mbet_pkg::ZW-1:0];
      k_q  <= k_q + 1'b1;
    end
    if (cmd_i.mul) begin
      rr_q <= zr_q * zr_q;
      ii_q <= zi_q * zi_q;
      ri_q <= zr_q * zi_q;
    end
    if (cmd_i.load_result) begin
      count_q <= sts_o.escaped ? k_q : '0;
    end
  end

  assign escape_count_o = count_q;

endmodule
`default_nettype wire

>>> hdl/mandelbrot_escape_time_top.sv
// Top level: configuration registers, controller and datapath of the escape-time unit.
//
//   channel  direction  handshake                     payload
//   in       input      in_valid_i / in_ready_o       col_i, row_i
//   out      output     out_valid_o / out_ready_i     escape_count_o
//   cfg      input      cfg_we_i (no wait)            cfg_idx_i, cfg_data_i
//
// An accepted pixel loads the step products and ST_FORM forms the point c; iterations
// then run until escape or the clamped iteration count. The next input transaction is
// taken only once the result is handed off and the controller is back in ST_IDLE; each
// iteration is a multiply and an add/compare state on the shared three-multiplier unit.
// Reset clears the controller and restores the registers (iteration count 30).
// A held result in the output register does not block the next input transaction;
// a finished pixel waits in the controller until that register is free.
`default_nettype none
module mandelbrot_escape_time_top #(
  parameter int unsigned INDEX_LIMIT = mbet_pkg::IndexLimitDef,
  parameter int unsigned ITER_LIMIT  = mbet_pkg::IterLimitDef
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire  [mbet_pkg::IdxW-1:0]          col_i,
  input  wire  [mbet_pkg::IdxW-1:0]          row_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic [mbet_pkg::CntW-1:0]          escape_count_o,
  input  wire                                cfg_we_i,
  input  wire  [mbet_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire  [mbet_pkg::QW-1:0]            cfg_data_i
);

  logic signed [mbet_pkg::QW-1:0]  x_first_q, y_first_q;
  logic [mbet_pkg::StepW-1:0]      x_step_q, y_step_q;
  logic [mbet_pkg::CntW-1:0]       max_iter_q;
  mbet_pkg::mbet_cmd_t             cmd;
  mbet_pkg::mbet_sts_t             sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_first_q  <= '0;
      x_step_q   <= '0;
      y_first_q  <= '0;
      y_step_q   <= '0;
      max_iter_q <= mbet_pkg::CntW'(mbet_pkg::DefaultIter);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mbet_pkg::REG_X_FIRST:  x_first_q  <= cfg_data_i;
        mbet_pkg::REG_X_STEP:   x_step_q   <= cfg_data_i[mbet_pkg::StepW-1:0];
        mbet_pkg::REG_Y_FIRST:  y_first_q  <= cfg_data_i;
        mbet_pkg::REG_Y_STEP:   y_step_q   <= cfg_data_i[mbet_pkg::StepW-1:0];
        mbet_pkg::REG_MAX_ITER: max_iter_q <= cfg_data_i[mbet_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  mbet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mbet_dp #(
    .INDEX_LIMIT (INDEX_LIMIT),
    .ITER_LIMIT  (ITER_LIMIT)
  ) u_dp (
    .clk_i          (clk_i),
    .col_i          (col_i),
    .row_i          (row_i),
    .x_first_i      (x_first_q),
    .x_step_i       (x_step_q),
    .y_first_i      (y_first_q),
    .y_step_i       (y_step_q),
    .max_iter_i     (max_iter_q),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .escape_count_o (escape_count_o)
  );

endmodule
`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Mandelbrot escape-time unit: predicts each count and compares.
module testbench;

  typedef struct packed {
    logic [mbet_pkg::IdxW-1:0] col;
    logic [mbet_pkg::IdxW-1:0] row;
  } pixel_t;

  localparam int     QOne         = 1 << mbet_pkg::FracBits;
  localparam longint TwoQ         = longint'(1) << (mbet_pkg::FracBits + 1);
  localparam longint FourWide     = longint'(1) << (2 * mbet_pkg::FracBits + 2);
  localparam int     IdxMax       = (1 << mbet_pkg::IdxW) - 1;
  localparam int     RegCount     = 5;
  localparam int     SettleCycles = 8;
  localparam int     MaxGap       = 10;
  localparam int     RandPhases   = 12;
  localparam int     PhaseItems   = 160;

  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         in_valid_i     = 1'b0;
  logic                         in_ready_o;
  logic [mbet_pkg::IdxW-1:0]    col_i          = '0;
  logic [mbet_pkg::IdxW-1:0]    row_i          = '0;
  logic                         out_valid_o;
  logic                         out_ready_i    = 1'b0;
  logic [mbet_pkg::CntW-1:0]    escape_count_o;
  logic                         cfg_we_i       = 1'b0;
  logic [mbet_pkg::CfgIdxW-1:0] cfg_idx_i      = '0;
  logic [mbet_pkg::QW-1:0]      cfg_data_i     = '0;

  // Register copy used by the predictor
  longint                    x_first_c = 0;
  longint                    x_step_c  = 0;
  longint                    y_first_c = 0;
  longint                    y_step_c  = 0;
  logic [mbet_pkg::CntW-1:0] iter_max_c = mbet_pkg::CntW'(mbet_pkg::DefaultIter);

  pixel_t                    pixel_q[$];
  logic [mbet_pkg::CntW-1:0] escape_due[$];
  int                        pixel_gap  = 0;
  int                        count_gap  = 0;
  bit                        pixel_took = 1'b0;
  bit                        count_took = 1'b0;
  bit                        idle_on    = 1'b1;
  bit                        failed     = 1'b0;

  mandelbrot_escape_time_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .col_i          (col_i),
    .row_i          (row_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .escape_count_o (escape_count_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint sat_q(longint v);
    if (v > longint'(mbet_pkg::QMax)) return longint'(mbet_pkg::QMax);
    if (v < longint'(mbet_pkg::QMin)) return longint'(mbet_pkg::QMin);
    return v;
  endfunction

  function automatic logic [mbet_pkg::CntW-1:0] escape_step(pixel_t px);
    longint                    cr, ci, zr, zi, nr, ni;
    int unsigned               k;
    logic [mbet_pkg::CntW-1:0] step_no;
    cr = sat_q(x_first_c + longint'(px.col) * x_step_c);
    ci = sat_q(y_first_c + longint'(px.row) * y_step_c);
    zr = 0;
    zi = 0;
    step_no = '0;
    for (k = 0; k < iter_max_c && step_no == '0; k++) begin
      nr = ((zr * zr - zi * zi) >>> mbet_pkg::FracBits) + cr;
      ni = ((2 * zr * zi) >>> mbet_pkg::FracBits) + ci;
      zr = nr;
      zi = ni;
      if (zr > TwoQ || zr < -TwoQ || zi > TwoQ || zi < -TwoQ) begin
        step_no = mbet_pkg::CntW'(k + 1);
      end else if (zr * zr + zi * zi > FourWide) begin
        step_no = mbet_pkg::CntW'(k + 1);
      end
    end
    return step_no;
  endfunction

  function automatic int gap_draw();
    return idle_on ? int'($urandom_range(0, MaxGap)) : 0;
  endfunction

  task automatic write_reg(input logic [mbet_pkg::CfgIdxW-1:0] idx,
                           input logic [mbet_pkg::QW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      mbet_pkg::REG_X_FIRST:  x_first_c  = longint'(signed'(data));
      mbet_pkg::REG_X_STEP:   x_step_c   = longint'(data[mbet_pkg::StepW-1:0]);
      mbet_pkg::REG_Y_FIRST:  y_first_c  = longint'(signed'(data));
      mbet_pkg::REG_Y_STEP:   y_step_c   = longint'(data[mbet_pkg::StepW-1:0]);
      mbet_pkg::REG_MAX_ITER: iter_max_c = data[mbet_pkg::CntW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_pixel(input int col, input int row);
    pixel_t px;
    px.col = mbet_pkg::IdxW'(col);
    px.row = mbet_pkg::IdxW'(row);
    pixel_q = {pixel_q, px};
  endtask

  task automatic await_idle();
    while (pixel_q.size() != 0 || in_valid_i || escape_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin : pixel_driver
    logic   v;
    pixel_t px;
    v = in_valid_i;
    px.col = col_i;
    px.row = row_i;
    if (v && pixel_took) begin
      v = 1'b0;
      pixel_gap = gap_draw();
    end
    pixel_took = 1'b0;
    if (!v) begin
      if (pixel_gap > 0) begin
        pixel_gap--;
      end else if (pixel_q.size() != 0) begin
        px = pixel_q.pop_front();
        v = 1'b1;
      end
    end
    in_valid_i <= v;
    col_i      <= px.col;
    row_i      <= px.row;
  end

  always @(negedge clk_i) begin : count_sink
    if (count_took) begin
      count_gap = gap_draw();
      count_took = 1'b0;
    end
    if (count_gap > 0) begin
      count_gap--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : monitor
    logic [mbet_pkg::CntW-1:0] want;
    pixel_t                    px;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        count_took = 1'b1;
        if (escape_due.size() == 0) begin
          failed = 1'b1;
          $display("%0t: escape_count expected none, actual %0d", $time, escape_count_o);
        end else begin
          want = escape_due.pop_front();
          if (escape_count_o !== want) begin
            failed = 1'b1;
            $display("%0t: escape_count expected %0d, actual %0d", $time, want, escape_count_o);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        px.col = col_i;
        px.row = row_i;
        escape_due = {escape_due, escape_step(px)};
        pixel_took = 1'b1;
      end
    end
  end

  initial begin : stimulus
    int   p, i, span_bits, sel;
    logic [mbet_pkg::QW-1:0] w;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values: c = 0 never escapes
    add_pixel(0, 0);
    add_pixel(IdxMax, IdxMax);
    await_idle();

    // classic view, full iteration budget
    write_reg(mbet_pkg::REG_X_FIRST, mbet_pkg::QW'(-2 * QOne));
    write_reg(mbet_pkg::REG_X_STEP, mbet_pkg::QW'(3 << (mbet_pkg::FracBits - mbet_pkg::IdxW)));
    write_reg(mbet_pkg::REG_Y_FIRST, mbet_pkg::QW'(-3 * QOne / 2));
    write_reg(mbet_pkg::REG_Y_STEP, mbet_pkg::QW'(3 << (mbet_pkg::FracBits - mbet_pkg::IdxW)));
    write_reg(mbet_pkg::REG_MAX_ITER, mbet_pkg::QW'(mbet_pkg::IterLimitDef));
    add_pixel(0, 0);
    add_pixel(IdxMax, IdxMax);
    add_pixel(0, 2048);
    add_pixel(1365, 2048);
    add_pixel(2048, 2048);
    add_pixel(IdxMax, 0);
    add_pixel(0, IdxMax);
    add_pixel(12'hAAA, 12'h555);
    await_idle();

    // saturated point, upper junk bits on step and count
    write_reg(mbet_pkg::REG_X_FIRST, mbet_pkg::QMax);
    write_reg(mbet_pkg::REG_X_STEP, '1);
    write_reg(mbet_pkg::REG_Y_FIRST, mbet_pkg::QMin);
    write_reg(mbet_pkg::REG_Y_STEP, '0);
    write_reg(mbet_pkg::REG_MAX_ITER, 32'hFFFF_FF01);
    add_pixel(IdxMax, 0);
    add_pixel(0, IdxMax);
    await_idle();

    // no iterations at all
    write_reg(mbet_pkg::REG_MAX_ITER, '0);
    add_pixel(IdxMax, IdxMax);
    add_pixel(0, 0);
    await_idle();

    // writes beyond the register list are dropped
    for (i = RegCount; i < (1 << mbet_pkg::CfgIdxW); i++) begin
      write_reg(mbet_pkg::CfgIdxW'(i), $urandom);
    end
    add_pixel(IdxMax, 12'h555);
    await_idle();

    for (p = 0; p < RandPhases; p++) begin
      idle_on = (p != 1) && ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 9);
      span_bits = (sel == 9) ? mbet_pkg::IdxW : int'($urandom_range(2, mbet_pkg::IdxW));
      if (sel >= 8) begin
        write_reg(mbet_pkg::REG_X_FIRST, $urandom);
        write_reg(mbet_pkg::REG_X_STEP, $urandom);
        write_reg(mbet_pkg::REG_Y_FIRST, $urandom);
        write_reg(mbet_pkg::REG_Y_STEP, $urandom);
      end else begin
        write_reg(mbet_pkg::REG_X_FIRST,
                  mbet_pkg::QW'(int'($urandom_range(0, 2 * QOne)) - 9 * (QOne / 4)));
        write_reg(mbet_pkg::REG_X_STEP,
                  mbet_pkg::QW'($urandom_range(1, 3 * QOne) >> span_bits));
        write_reg(mbet_pkg::REG_Y_FIRST,
                  mbet_pkg::QW'(int'($urandom_range(0, 2 * QOne)) - 3 * QOne / 2));
        write_reg(mbet_pkg::REG_Y_STEP,
                  mbet_pkg::QW'($urandom_range(1, 3 * QOne) >> span_bits));
      end
      case ($urandom_range(0, 5))
        0:       w = {24'($urandom_range(0, 255)), 8'(mbet_pkg::IterLimitDef)};
        1:       w = mbet_pkg::QW'($urandom_range(0, 3));
        default: w = {24'($urandom_range(0, 255)), 8'($urandom_range(1, 100))};
      endcase
      write_reg(mbet_pkg::REG_MAX_ITER, w);
      for (i = 0; i < PhaseItems; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          add_pixel($urandom_range(0, IdxMax), $urandom_range(0, IdxMax));
        end else begin
          add_pixel($urandom_range(0, (1 << span_bits) - 1),
                    $urandom_range(0, (1 << span_bits) - 1));
        end
        if (p == 3 && i == PhaseItems / 2) await_idle();
      end
      await_idle();
    end

    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #60_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
